FILE: hdl/rtsd_pkg.sv
package rtsd_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int OPCODE_WIDTH  = 2;

  localparam logic [OPCODE_WIDTH-1:0] OP_HYPOTENUSE = 2'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_LEG_B      = 2'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_LEG_A      = 2'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_DISTANCE   = 2'd3;

endpackage

FILE: hdl/rtsd_req_if.sv
interface rtsd_req_if #(
  parameter int W = rtsd_pkg::OPERAND_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic [rtsd_pkg::OPCODE_WIDTH-1:0] opcode;
  logic signed [W-1:0]               leg_a;
  logic signed [W-1:0]               leg_b;
  logic signed [W-1:0]               hyp_c;
  logic signed [W-1:0]               first_x;
  logic signed [W-1:0]               first_y;
  logic signed [W-1:0]               second_x;
  logic signed [W-1:0]               second_y;

  modport source (
    output valid, opcode, leg_a, leg_b, hyp_c, first_x, first_y, second_x, second_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, leg_a, leg_b, hyp_c, first_x, first_y, second_x, second_y,
    output ready
  );
endinterface

FILE: hdl/rtsd_res_if.sv
interface rtsd_res_if #(
  parameter int W = rtsd_pkg::OPERAND_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic signed [2*W+1:0] radicand;
  logic [W:0]            root;
  logic                  invalid;

  modport source (
    output valid, radicand, root, invalid,
    input  ready
  );
  modport sink (
    input  valid, radicand, root, invalid,
    output ready
  );
endinterface

FILE: hdl/right_triangle_side_and_distance_top.sv
// Hypotenuse, missing leg and point distance on signed fixed-point operands.
// Each request gives one result: the radicand (sum or difference of squares,
// twice the operand fraction bits), its floored square root (operand fraction
// bits), and an invalid flag when the radicand is negative, with the root then
// zero. One request is accepted every cycle while the output is not stalled.
// There are register stages for operand select, squaring and combine, then a
// row of OPERAND_WIDTH + 1 square-root cells, each giving one root bit, the
// last of which is the output register. Each stage holds its item only while
// the stage after it is full and stalled.
module right_triangle_side_and_distance_top #(
  parameter int OPERAND_WIDTH = rtsd_pkg::OPERAND_WIDTH
) (
  input logic        clk,
  input logic        rst,
  rtsd_req_if.sink   req,
  rtsd_res_if.source res
);

  localparam int R = OPERAND_WIDTH + 1;

  logic                  valid [0:R];
  logic                  ready [0:R];
  logic signed [2*R-1:0] rad   [0:R];
  logic [2*R-1:0]        bits  [0:R];
  logic [R+1:0]          rem   [0:R];
  logic [R-1:0]          root  [0:R];
  logic                  inv   [0:R];

  rtsd_front #(.W(OPERAND_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .opcode      (req.opcode),
    .leg_a       (req.leg_a),
    .leg_b       (req.leg_b),
    .hyp_c       (req.hyp_c),
    .first_x     (req.first_x),
    .first_y     (req.first_y),
    .second_x    (req.second_x),
    .second_y    (req.second_y),
    .out_valid   (valid[0]),
    .out_ready   (ready[0]),
    .out_rad     (rad[0]),
    .out_invalid (inv[0])
  );

  // a negative radicand runs through the root cells as zero
  assign bits[0] = inv[0] ? '0 : rad[0];
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < R; i++) begin : g_cell
    rtsd_cell #(.R(R)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_valid    (valid[i]),
      .in_ready    (ready[i]),
      .in_rad      (rad[i]),
      .in_bits     (bits[i]),
      .in_rem      (rem[i]),
      .in_root     (root[i]),
      .in_invalid  (inv[i]),
      .out_valid   (valid[i+1]),
      .out_ready   (ready[i+1]),
      .out_rad     (rad[i+1]),
      .out_bits    (bits[i+1]),
      .out_rem     (rem[i+1]),
      .out_root    (root[i+1]),
      .out_invalid (inv[i+1])
    );
  end

  assign res.valid    = valid[R];
  assign ready[R]     = res.ready;
  assign res.radicand = rad[R];
  assign res.root     = root[R];
  assign res.invalid  = inv[R];

  a_invalid_zero_root: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.invalid |-> res.root == '0)
    else $error("invalid result with nonzero root");

  a_invalid_sign: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.invalid == res.radicand[2*R-1])
    else $error("invalid flag does not match radicand sign");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    (!res.valid || res.ready) |-> req.ready)
    else $error("input stalled while output side can move");

endmodule

FILE: hdl/rtsd_front.sv
module rtsd_front #(
  parameter int W = rtsd_pkg::OPERAND_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rtsd_pkg::OPCODE_WIDTH-1:0] opcode,
  input  logic signed [W-1:0]               leg_a,
  input  logic signed [W-1:0]               leg_b,
  input  logic signed [W-1:0]               hyp_c,
  input  logic signed [W-1:0]               first_x,
  input  logic signed [W-1:0]               first_y,
  input  logic signed [W-1:0]               second_x,
  input  logic signed [W-1:0]               second_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [2*W+1:0]             out_rad,
  output logic                              out_invalid
);

  // operand select
  logic            a_valid;
  logic signed [W:0] a_p, a_q;
  logic            a_sub;
  logic signed [W:0] p_next, q_next;
  logic            sub_next;
  logic signed [W:0] dx, dy;

  // squares
  logic            b_valid;
  logic [2*W:0]    b_sq_p, b_sq_q;
  logic            b_sub;
  logic signed [2*W+1:0] prod_p, prod_q;

  // combine
  logic            c_valid;
  logic signed [2*W+1:0] c_rad;
  logic            c_invalid;
  logic signed [2*W+1:0] rad_next;

  logic a_ready, b_ready, c_ready;

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign dx = $signed({second_x[W-1], second_x}) - $signed({first_x[W-1], first_x});
  assign dy = $signed({second_y[W-1], second_y}) - $signed({first_y[W-1], first_y});

  always_comb begin
    unique case (opcode)
      rtsd_pkg::OP_HYPOTENUSE: begin
        p_next   = {leg_a[W-1], leg_a};
        q_next   = {leg_b[W-1], leg_b};
        sub_next = 1'b0;
      end
      rtsd_pkg::OP_LEG_B: begin
        p_next   = {hyp_c[W-1], hyp_c};
        q_next   = {leg_a[W-1], leg_a};
        sub_next = 1'b1;
      end
      rtsd_pkg::OP_LEG_A: begin
        p_next   = {hyp_c[W-1], hyp_c};
        q_next   = {leg_b[W-1], leg_b};
        sub_next = 1'b1;
      end
      default: begin
        p_next   = dx;
        q_next   = dy;
        sub_next = 1'b0;
      end
    endcase
  end

  assign prod_p = (2*W+2)'(a_p) * (2*W+2)'(a_p);
  assign prod_q = (2*W+2)'(a_q) * (2*W+2)'(a_q);

  // a sum of two squares never sets the sign bit, so only a difference can go negative
  assign rad_next = b_sub ? ($signed({1'b0, b_sq_p}) - $signed({1'b0, b_sq_q}))
                          : ($signed({1'b0, b_sq_p}) + $signed({1'b0, b_sq_q}));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_p   <= p_next;
      a_q   <= q_next;
      a_sub <= sub_next;
    end
    if (b_ready && a_valid) begin
      b_sq_p <= prod_p[2*W:0];
      b_sq_q <= prod_q[2*W:0];
      b_sub  <= a_sub;
    end
    if (c_ready && b_valid) begin
      c_rad     <= rad_next;
      c_invalid <= rad_next[2*W+1];
    end
  end

  assign out_valid   = c_valid;
  assign out_rad     = c_rad;
  assign out_invalid = c_invalid;

endmodule

FILE: hdl/rtsd_cell.sv
module rtsd_cell #(
  parameter int R = rtsd_pkg::OPERAND_WIDTH + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [2*R-1:0] in_rad,
  input  logic [2*R-1:0]      in_bits,
  input  logic [R+1:0]        in_rem,
  input  logic [R-1:0]        in_root,
  input  logic                in_invalid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [2*R-1:0] out_rad,
  output logic [2*R-1:0]      out_bits,
  output logic [R+1:0]        out_rem,
  output logic [R-1:0]        out_root,
  output logic                out_invalid
);

  logic       valid;
  logic [R+1:0] rem_sh, trial;
  logic       take;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {in_rem[R-1:0], in_bits[2*R-1:2*R-2]};
  assign trial  = {in_root, 2'b01};
  assign take   = rem_sh >= trial;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rad     <= in_rad;
      out_bits    <= {in_bits[2*R-3:0], 2'b00};
      out_rem     <= take ? (rem_sh - trial) : rem_sh;
      out_root    <= {in_root[R-2:0], take};
      out_invalid <= in_invalid;
    end
  end

  assign out_valid = valid;

endmodule
